// ===== rtl/tif_pkg.sv =====
// Shared types, constants and helpers for the socket-table inode filter.
// No dependencies; imported by the core and its port checker.
package tif_pkg;

    localparam int BYTE_W     = 8;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int OUT_CNT_W  = 16;
    localparam int M_TDATA_W  = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PORT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 8'd1;

    localparam logic [REG_W-1:0] LOCAL_PORT_RST = 16'd22;
    localparam logic [REG_W-1:0] CAPACITY_RST   = 16'd32764;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;  // '\n'
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [BYTE_W-1:0] CH_HEX_A = 8'h37;  // 'A' - 10

    typedef enum logic [22:0] {
        PH_HDR  = 23'h000001,
        PH_COL1 = 23'h000002,
        PH_COL2 = 23'h000004,
        PH_P0   = 23'h000008,
        PH_P1   = 23'h000010,
        PH_P2   = 23'h000020,
        PH_P3   = 23'h000040,
        PH_PSP  = 23'h000080,
        PH_REM  = 23'h000100,
        PH_ST0  = 23'h000200,
        PH_ST1  = 23'h000400,
        PH_C3   = 23'h000800,
        PH_C4   = 23'h001000,
        PH_S1   = 23'h002000,
        PH_S2   = 23'h004000,
        PH_S3   = 23'h008000,
        PH_UID  = 23'h010000,
        PH_S4   = 23'h020000,
        PH_TMO  = 23'h040000,
        PH_INO0 = 23'h080000,
        PH_INO1 = 23'h100000,
        PH_WEOL = 23'h200000,
        PH_HALT = 23'h400000
    } phase_t;

    // Upper-case hex character for one nibble
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'd0, nib};
        end
        return CH_HEX_A + {4'd0, nib};
    endfunction

    // A failed test still looks at the byte: a newline starts the next row
    function automatic phase_t reject(input logic [BYTE_W-1:0] b);
        return (b == CH_NL) ? PH_COL1 : PH_WEOL;
    endfunction

endpackage

// ===== rtl/tcp_table_inode_filter_core.sv =====
// Socket-table inode filter: byte-wide parser, budget counters, result register.
// Depends on tif_pkg.

// Takes a TCP socket table as text, one byte per beat, and returns the inode
// numbers of rows whose local port matches local_port and whose state is not
// listening, each followed by '/'. A beat is accepted in every cycle unless a
// result sits in the output register and the sink stalls; each byte is parsed
// in the cycle it is accepted and its result (if any) is shown on the next
// cycle, so throughput is one byte per clock unless the sink stalls. A result
// appears only for a copied character or for the last byte of a stream
// (s_tlast), which carries the running count and the truncated flag. The
// capacity register is loaded into the byte budget on the first byte of a
// stream; one byte per row is held back for the '/'. Once the budget runs out
// the parser halts until the end of the stream. Write configuration only
// while no stream is in flight.
module tcp_table_inode_filter_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tif_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,   // in_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tif_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [23:8] total_count,
                                                      // [24] truncated, [31:25] zero
    output logic                           m_tuser,   // byte_valid
    output logic                           m_tlast,   // stream_end
    input  logic                           cfg_wr_en,
    input  logic [tif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tif_pkg::REG_W-1:0]      cfg_wdata
);
    import tif_pkg::*;

    logic [REG_W-1:0]      local_port_reg;
    logic [REG_W-1:0]      capacity_reg;
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] budget_reg, budget_next, budget_cur, cap_cnt;
    logic [COUNT_BITS-1:0] emitted_reg, emitted_next;
    logic                  started_reg;
    logic [COUNT_BITS+REG_W-1:0] cap_ext, emitted_ext;

    logic                  accept;
    logic                  emit;
    logic [BYTE_W-1:0]     ob;
    logic [BYTE_W-1:0]     b;
    logic                  budget_ge2;

    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  byte_valid_reg;
    logic                  end_reg;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic                  trunc_reg;

    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cap_ext    = {{COUNT_BITS{1'b0}}, capacity_reg};
    assign cap_cnt    = cap_ext[COUNT_BITS-1:0];
    assign budget_cur = started_reg ? budget_reg : cap_cnt;
    assign budget_ge2 = (budget_cur[COUNT_BITS-1:1] != '0);

    always_comb begin
        phase_next  = phase_reg;
        budget_next = budget_cur;
        emit        = 1'b0;
        ob          = '0;
        case (phase_reg)
            PH_HDR:  if (b == CH_NL) phase_next = PH_COL1;
            PH_COL1: if (b == CH_COLON) phase_next = PH_COL2;
            PH_COL2: if (b == CH_COLON) phase_next = PH_P0;
            PH_P0:   phase_next = (b == hex_char(local_port_reg[15:12])) ? PH_P1 : reject(b);
            PH_P1:   phase_next = (b == hex_char(local_port_reg[11:8]))  ? PH_P2 : reject(b);
            PH_P2:   phase_next = (b == hex_char(local_port_reg[7:4]))   ? PH_P3 : reject(b);
            PH_P3:   phase_next = (b == hex_char(local_port_reg[3:0]))   ? PH_PSP : reject(b);
            PH_PSP:  phase_next = (b == CH_SPACE) ? PH_REM : reject(b);
            PH_REM:  if (b == CH_SPACE) phase_next = PH_ST0;
            PH_ST0:  phase_next = (b == CH_ZERO) ? PH_ST1 : reject(b);
            PH_ST1:  phase_next = (b == CH_A) ? reject(b) : PH_C3;
            PH_C3:   if (b == CH_COLON) phase_next = PH_C4;
            PH_C4:   if (b == CH_COLON) phase_next = PH_S1;
            PH_S1:   if (b == CH_SPACE) phase_next = PH_S2;
            PH_S2:   if (b == CH_SPACE) phase_next = PH_S3;
            PH_S3:   if (b != CH_SPACE) phase_next = PH_UID;
            PH_UID:  if (b == CH_SPACE) phase_next = PH_S4;
            PH_S4:   if (b != CH_SPACE) phase_next = PH_TMO;
            PH_TMO:  if (b == CH_SPACE) phase_next = PH_INO0;
            PH_INO0: begin
                if (b == CH_ZERO) begin
                    phase_next = PH_WEOL;
                end else if (!budget_ge2) begin
                    // nothing left for a digit plus the reserved '/'
                    phase_next = PH_HALT;
                end else begin
                    emit        = 1'b1;
                    ob          = b;
                    budget_next = budget_cur - COUNT_BITS'(2);
                    phase_next  = PH_INO1;
                end
            end
            PH_INO1: begin
                if (b == CH_SPACE) begin
                    emit       = 1'b1;
                    ob         = CH_SLASH;
                    phase_next = PH_WEOL;
                end else if (budget_cur == '0) begin
                    phase_next = PH_HALT;
                end else begin
                    emit        = 1'b1;
                    ob          = b;
                    budget_next = budget_cur - COUNT_BITS'(1);
                end
            end
            PH_WEOL: if (b == CH_NL) phase_next = PH_COL1;
            default: phase_next = PH_HALT;
        endcase
    end

    assign emitted_next = emitted_reg + COUNT_BITS'(emit);
    assign emitted_ext  = {{REG_W{1'b0}}, emitted_next};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_port_reg <= LOCAL_PORT_RST;
            capacity_reg   <= CAPACITY_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_LOCAL_PORT) begin
                local_port_reg <= cfg_wdata;
            end else if (cfg_index == REG_CAPACITY) begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // Parser state; the last byte returns everything to the stream start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            budget_reg  <= '0;
            emitted_reg <= '0;
            started_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                phase_reg   <= PH_HDR;
                emitted_reg <= '0;
                started_reg <= 1'b0;
            end else begin
                phase_reg   <= phase_next;
                emitted_reg <= emitted_next;
                started_reg <= 1'b1;
            end
            budget_reg <= budget_next;
        end
    end

    // Result register: load on a beat that emits or ends the stream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && (emit || s_tlast)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (emit || s_tlast)) begin
            out_byte_reg   <= ob;
            byte_valid_reg <= emit;
            end_reg        <= s_tlast;
            count_reg      <= emitted_ext[OUT_CNT_W-1:0];
            trunc_reg      <= (phase_next == PH_HALT);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, trunc_reg, count_reg, out_byte_reg};
    assign m_tuser  = byte_valid_reg;
    assign m_tlast  = end_reg;

endmodule

// ===== rtl/tif_port_check.sv =====
// Port-level checker for the socket-table inode filter, bound to the core.
// Depends on tif_pkg for port widths.
module tif_port_check (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tif_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import tif_pkg::*;

    // No result may be left over from before reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A beat without a character only exists to close the stream
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("empty result without stream end");

    // Once halted, nothing more is copied
    a_trunc_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> !m_tuser)
        else $error("character emitted after truncation");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:25] == '0))
        else $error("pad bits set");

endmodule

bind tcp_table_inode_filter_core tif_port_check u_tif_port_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
